[hdl/smpt_pkg.sv]
// ----------------------------------------------------------------------------
// smpt_pkg
// Shared types and constants of the soil moisture pump trigger unit.
// ----------------------------------------------------------------------------
package smpt_pkg;

  localparam int ADC_W    = 12;
  localparam int CFG_W    = 12;
  localparam int CIDX_W   = 3;
  localparam int RPM_W    = 5;
  localparam int PCT_W    = 7;
  localparam int STREAK_W = 4;
  localparam int PROD_W   = 19;
  localparam int PCT_MAX  = 100;

  localparam logic [CIDX_W-1:0] REG_DRY_LEVEL  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_WET_LEVEL  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_READINGS   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DRY_RUNS   = 3'd4;

  localparam logic [ADC_W-1:0]    DRY_LEVEL_RST = 12'd2754;
  localparam logic [ADC_W-1:0]    WET_LEVEL_RST = 12'd1070;
  localparam logic [RPM_W-1:0]    READINGS_RST  = 5'd10;
  localparam logic [PCT_W-1:0]    THRESHOLD_RST = 7'd20;
  localparam logic [STREAK_W-1:0] DRY_RUNS_RST  = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_SCALE,
    ST_DIV_PCT,
    ST_RESULT
  } smpt_state_t;

endpackage

[hdl/soil_moisture_pump_trigger_unit.sv]
// ----------------------------------------------------------------------------
// soil_moisture_pump_trigger_unit
// Averages moisture samples per measurement, maps to percent, fires pump.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one converter sample per request (valid/ready).
//   out_* : one result per closed measurement (valid/ready), held in an
//           output register until taken.
//   cfg_* : register writes, applied at the edge where cfg_we is high.
// A sample that does not close a measurement is added to the running sum
// and the unit stays ready. The closing sample runs two divisions on one
// shared bit-serial divider (average, then percent scaling) of width
// DivW (19 at default parameters); in_ready is low until the result is
// loaded into the output register, so no new sample is taken meanwhile.
// A stalled receiver holds the result; non-closing samples are still taken,
// and a new result waits until the previous one is taken.
// Reset (synchronous, active low) loads the default calibration and clears
// the running sum, sample count, dry streak and the output valid flag.
// ----------------------------------------------------------------------------
module soil_moisture_pump_trigger_unit #(
  parameter int SAMPLE_BITS  = 12,
  parameter int MAX_READINGS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [smpt_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [smpt_pkg::ADC_W-1:0]     out_avg_level,
  output logic [smpt_pkg::PCT_W-1:0]     out_wet_percent,
  output logic                           out_is_dry,
  output logic                           out_pump_fire,
  output logic [smpt_pkg::STREAK_W-1:0]  out_dry_run_count,
  input  logic                           cfg_we,
  input  logic [smpt_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [smpt_pkg::CFG_W-1:0]     cfg_wdata
);

  import smpt_pkg::*;

  localparam int SumW = ADC_W + $clog2(MAX_READINGS + 1);
  localparam int DivW = (SumW > PROD_W) ? SumW : PROD_W;
  localparam logic [ADC_W-1:0] SampleMask = ADC_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  // configuration
  logic [ADC_W-1:0]    dry_r, wet_r;
  logic [RPM_W-1:0]    rpm_r;
  logic [PCT_W-1:0]    thr_r;
  logic [STREAK_W-1:0] runs_r;

  // state
  smpt_state_t         state_r, state_nxt;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [RPM_W-1:0]    taken_r, taken_nxt;
  logic [STREAK_W-1:0] streak_r, streak_nxt;
  logic [ADC_W-1:0]    avg_r;
  logic                neg_r, zspan_r;
  logic [PCT_W-1:0]    pct_r;

  logic                out_valid_r, out_valid_nxt;
  logic [ADC_W-1:0]    o_avg_r;
  logic [PCT_W-1:0]    o_pct_r;
  logic                o_dry_r, o_fire_r;
  logic [STREAK_W-1:0] o_cnt_r;

  // datapath
  logic                accept, closing;
  logic [RPM_W-1:0]    n_eff;
  logic [STREAK_W-1:0] need;
  logic [SumW-1:0]     sum_tot;
  logic [RPM_W-1:0]    taken_inc;
  logic signed [ADC_W:0] diff, span;
  logic [ADC_W-1:0]    diff_mag, span_mag;
  logic [PROD_W-1:0]   prod;
  logic [DivW-1:0]     div_dividend;
  logic [ADC_W-1:0]    div_divisor;
  logic                div_start, div_done;
  logic [DivW-1:0]     div_q;
  logic                avg_load, pct_load, res_load;
  logic [PCT_W-1:0]    pct_calc;
  logic                is_dry;
  logic [STREAK_W-1:0] streak_inc;
  logic                fire;

  always_comb begin
    if (rpm_r == '0) begin
      n_eff = RPM_W'(1);
    end else if (int'(rpm_r) > MAX_READINGS) begin
      n_eff = RPM_W'(MAX_READINGS);
    end else begin
      n_eff = rpm_r;
    end
    need = (runs_r == '0) ? STREAK_W'(1) : runs_r;
  end

  assign accept    = in_valid && in_ready;
  assign sum_tot   = sum_r + SumW'(in_adc_sample & SampleMask);
  assign taken_inc = taken_r + RPM_W'(1);
  assign closing   = taken_inc >= n_eff;

  assign diff     = $signed({1'b0, avg_r}) - $signed({1'b0, dry_r});
  assign span     = $signed({1'b0, wet_r}) - $signed({1'b0, dry_r});
  assign diff_mag = diff[ADC_W] ? ADC_W'(-diff) : diff[ADC_W-1:0];
  assign span_mag = span[ADC_W] ? ADC_W'(-span) : span[ADC_W-1:0];
  assign prod     = PROD_W'(diff_mag) * PROD_W'(PCT_MAX);

  assign div_dividend = (state_r == ST_IDLE) ? DivW'(sum_tot) : DivW'(prod);
  assign div_divisor  = (state_r == ST_IDLE) ? ADC_W'(n_eff) : span_mag;

  smpt_div #(
    .DIV_W (DivW),
    .DVS_W (ADC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (zspan_r || neg_r) begin
      pct_calc = '0;
    end else if (div_q > DivW'(PCT_MAX)) begin
      pct_calc = PCT_W'(PCT_MAX);
    end else begin
      pct_calc = div_q[PCT_W-1:0];
    end
  end

  assign is_dry     = pct_r < thr_r;
  assign streak_inc = streak_r + STREAK_W'(1);
  assign fire       = is_dry && (streak_inc >= need);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && closing) begin
          state_nxt = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_DIV_PCT;
      ST_DIV_PCT: begin
        if (div_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    avg_load  = 1'b0;
    pct_load  = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid && closing;
      end
      ST_DIV_AVG: avg_load = div_done;
      ST_SCALE:   div_start = 1'b1;
      ST_DIV_PCT: pct_load = div_done;
      ST_RESULT:  res_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    sum_nxt   = sum_r;
    taken_nxt = taken_r;
    if (accept) begin
      sum_nxt   = closing ? '0 : sum_tot;
      taken_nxt = closing ? '0 : taken_inc;
    end
    streak_nxt = streak_r;
    if (res_load) begin
      streak_nxt = (is_dry && !fire) ? streak_inc : '0;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      taken_r     <= '0;
      streak_r    <= '0;
      out_valid_r <= 1'b0;
      dry_r       <= DRY_LEVEL_RST;
      wet_r       <= WET_LEVEL_RST;
      rpm_r       <= READINGS_RST;
      thr_r       <= THRESHOLD_RST;
      runs_r      <= DRY_RUNS_RST;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      taken_r     <= taken_nxt;
      streak_r    <= streak_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DRY_LEVEL: dry_r  <= cfg_wdata[ADC_W-1:0];
          REG_WET_LEVEL: wet_r  <= cfg_wdata[ADC_W-1:0];
          REG_READINGS:  rpm_r  <= cfg_wdata[RPM_W-1:0];
          REG_THRESHOLD: thr_r  <= cfg_wdata[PCT_W-1:0];
          REG_DRY_RUNS:  runs_r <= cfg_wdata[STREAK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (avg_load) begin
      avg_r <= div_q[ADC_W-1:0];
    end
    if (div_start && (state_r == ST_SCALE)) begin
      neg_r   <= diff[ADC_W] ^ span[ADC_W];
      zspan_r <= (span == '0);
    end
    if (pct_load) begin
      pct_r <= pct_calc;
    end
    if (res_load) begin
      o_avg_r  <= avg_r;
      o_pct_r  <= pct_r;
      o_dry_r  <= is_dry;
      o_fire_r <= fire;
      o_cnt_r  <= (is_dry && !fire) ? streak_inc : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_avg_level     = o_avg_r;
  assign out_wet_percent   = o_pct_r;
  assign out_is_dry        = o_dry_r;
  assign out_pump_fire     = o_fire_r;
  assign out_dry_run_count = o_cnt_r;

endmodule

[hdl/smpt_div.sv]
// ----------------------------------------------------------------------------
// smpt_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smpt_div #(
  parameter int DIV_W = 19,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_diff;
  logic             ge;

  assign rem_sh   = {rem_r, q_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      q_nxt    = {q_r[DIV_W-2:0], ge};
      rem_nxt  = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
